// ===== design/ttps_pkg.sv =====
package ttps_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SIG_ENTRIES = 256;
    localparam int SIG_IDXW    = $clog2(SIG_ENTRIES);

    localparam int MW      = 23;
    localparam int TW      = 24;
    localparam int STEPW   = 21;
    localparam int STRESSW = 31;
    localparam int RESW    = 32;
    localparam int GRADW   = 32;

    localparam int SLOPE = 10;

    // sigmoid values are Q1.16 whatever FRAC_BITS is
    localparam int SIGW = 17;
    localparam logic [SIGW-1:0] SIG_ONE = SIGW'(65536);

    localparam logic [STEPW-1:0] STEP_RESET = STEPW'(64'd1 << FRAC_BITS);

    // internal widths
    localparam int AW      = TW + 2;                    // t - m + step
    localparam int MAGW    = AW - 1;
    localparam int SQW     = 2 * MAGW - FRAC_BITS;
    localparam int PSW     = SQW + SIGW - 16;           // less-than stress before clip
    localparam int RW      = MAGW + SIGW - 16;          // |x| * s
    localparam int RESIDW  = RW + 1;
    localparam int DSW     = 18;                        // s * (1 - s)
    localparam int PRODW   = SQW + DSW - 16;
    localparam int NUMW    = PRODW + 5;                 // 10 * prod + 2 * r, signed
    localparam int DIVN    = NUMW + FRAC_BITS;
    localparam int DSTG    = (DIVN + 1) / 2;            // two quotient bits per stage
    localparam int DIVNP   = 2 * DSTG;

    typedef enum logic [1:0] {
        KIND_MISSING    = 2'd0,
        KIND_MEASURABLE = 2'd1,
        KIND_LESS       = 2'd2,
        KIND_MORE       = 2'd3
    } t_kind;

    typedef struct packed {
        logic [MW-1:0]        map_distance;
        logic signed [TW-1:0] table_distance;
        logic [1:0]           titer_kind;
    } t_in_item;

    typedef struct packed {
        logic [STRESSW-1:0]     stress;
        logic signed [RESW-1:0] residual;
        logic signed [GRADW-1:0] gradient_base;
        logic                   saturated;
    } t_out_item;

    // stress and residual riding along the divider
    typedef struct packed {
        logic [PSW-1:0]           stress;
        logic signed [RESIDW-1:0] resid;
    } t_side;

    typedef logic [SIGW-1:0] t_sig_rom [SIG_ENTRIES];

    // shift-subtract quotient, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-a), a and result in Q32
    function automatic logic [63:0] exp_neg_q32(input logic [63:0] a);
        logic [63:0] whole;
        logic [63:0] f;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] u;
        int i;
        whole = a >> 32;
        f     = a & 64'hFFFF_FFFF;
        term  = 64'd1 << 32;
        sum   = term;
        if (whole > 64'd40) begin
            return 64'd0;
        end
        for (i = 1; i <= 14; i++) begin
            term = udiv64((term * f) >> 32, 64'(i));
            if (i[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        u = sum;
        for (i = 0; i < int'(whole); i++) begin
            u = (u * 64'd1580030169) >> 32;
        end
        return u;
    endfunction

    function automatic logic [SIGW-1:0] sig_entry(input int k);
        longint num;
        logic [63:0] mag;
        logic [63:0] u;
        logic [63:0] den;
        logic [63:0] p;
        num = longint'(SLOPE) * 2 * (longint'(2 * k + 1) - longint'(SIG_ENTRIES));
        mag = (num < 0) ? 64'(-num) : 64'(num);
        u   = exp_neg_q32((mag << 32) >> SIG_IDXW);
        den = (64'd1 << 32) + u;
        p   = udiv64((64'd1 << 48) + (den >> 1), den);
        if (num >= 0) begin
            return SIGW'(p);
        end
        return SIGW'(64'd65536 - p);
    endfunction

    function automatic t_sig_rom sig_rom_build();
        t_sig_rom rom;
        for (int k = 0; k < SIG_ENTRIES; k++) begin
            rom[k] = sig_entry(k);
        end
        return rom;
    endfunction

    localparam t_sig_rom SIG_ROM = sig_rom_build();

    // bin of x in [-2, 2), clamped at both ends
    function automatic logic [SIG_IDXW-1:0] sig_index(input logic signed [AW-1:0] x);
        logic signed [AW+1:0] xo;
        logic [63:0] w;
        xo = (AW+2)'(x) + (AW+2)'(64'd2 << FRAC_BITS);
        if (xo < 0) begin
            return '0;
        end
        w = (64'(xo) * 64'(SIG_ENTRIES)) >> (FRAC_BITS + 2);
        if (w >= 64'(SIG_ENTRIES)) begin
            return SIG_IDXW'(SIG_ENTRIES - 1);
        end
        return SIG_IDXW'(w);
    endfunction

endpackage

// ===== design/ttps_front.sv =====
module ttps_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  ttps_pkg::t_in_item           i_item,
    input  logic [ttps_pkg::STEPW-1:0]   i_step,
    output logic                         o_valid,
    output logic [ttps_pkg::NUMW-1:0]    o_num_mag,
    output logic                         o_neg,
    output logic [ttps_pkg::MW-1:0]      o_mg,
    output ttps_pkg::t_side              o_side
);

    localparam int AW     = ttps_pkg::AW;
    localparam int MAGW   = ttps_pkg::MAGW;
    localparam int SQW    = ttps_pkg::SQW;
    localparam int SIGW   = ttps_pkg::SIGW;
    localparam int RW     = ttps_pkg::RW;
    localparam int RESIDW = ttps_pkg::RESIDW;
    localparam int DSW    = ttps_pkg::DSW;
    localparam int PRODW  = ttps_pkg::PRODW;
    localparam int PSW    = ttps_pkg::PSW;
    localparam int NUMW   = ttps_pkg::NUMW;
    localparam int MW     = ttps_pkg::MW;
    localparam int FB     = ttps_pkg::FRAC_BITS;

    // stage 1: differences
    logic                  r1_valid;
    logic [1:0]            r1_kind;
    logic signed [AW-1:0]  r1_a, r1_ag;
    logic [MW-1:0]         r1_mg;

    logic [MW-1:0]         n1_mg;
    logic [AW-1:0]         n1_add;
    logic signed [AW-1:0]  n1_a, n1_ag;

    always_comb begin
        n1_mg  = (i_item.map_distance == '0) ? MW'(1) : i_item.map_distance;
        n1_add = (i_item.titer_kind == ttps_pkg::KIND_LESS) ? AW'(i_step) : '0;
        n1_a   = AW'(i_item.table_distance) - AW'(i_item.map_distance) + n1_add;
        n1_ag  = AW'(i_item.table_distance) - AW'(n1_mg) + n1_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_kind <= i_item.titer_kind;
            r1_a    <= n1_a;
            r1_ag   <= n1_ag;
            r1_mg   <= n1_mg;
        end
    end

    // stage 2: magnitudes, squares, sigmoid lookups
    logic                  r2_valid;
    logic [1:0]            r2_kind;
    logic signed [AW-1:0]  r2_a, r2_ag;
    logic [MAGW-1:0]       r2_maga, r2_magag;
    logic [SQW-1:0]        r2_sq, r2_sqg;
    logic [SIGW-1:0]       r2_s, r2_sg;
    logic [MW-1:0]         r2_mg;

    logic [MAGW-1:0]       n2_maga, n2_magag;
    logic [2*MAGW-1:0]     n2_sqf, n2_sqgf;

    always_comb begin
        n2_maga  = r1_a[AW-1]  ? MAGW'(-r1_a)  : MAGW'(r1_a);
        n2_magag = r1_ag[AW-1] ? MAGW'(-r1_ag) : MAGW'(r1_ag);
        n2_sqf   = (2*MAGW)'(n2_maga) * (2*MAGW)'(n2_maga);
        n2_sqgf  = (2*MAGW)'(n2_magag) * (2*MAGW)'(n2_magag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_kind  <= r1_kind;
            r2_a     <= r1_a;
            r2_ag    <= r1_ag;
            r2_maga  <= n2_maga;
            r2_magag <= n2_magag;
            r2_sq    <= SQW'(n2_sqf >> FB);
            r2_sqg   <= SQW'(n2_sqgf >> FB);
            r2_s     <= ttps_pkg::SIG_ROM[ttps_pkg::sig_index(r1_a)];
            r2_sg    <= ttps_pkg::SIG_ROM[ttps_pkg::sig_index(r1_ag)];
            r2_mg    <= r1_mg;
        end
    end

    // stage 3: products with s, derivative of the sigmoid
    logic                  r3_valid;
    logic [1:0]            r3_kind;
    logic signed [AW-1:0]  r3_ag;
    logic [SQW-1:0]        r3_sqg;
    logic [DSW-1:0]        r3_dsg;
    logic [RW-1:0]         r3_rg;
    logic [MW-1:0]         r3_mg;
    ttps_pkg::t_side       r3_side;

    logic [2*SIGW-1:0]     n3_dsf;
    logic [SQW+SIGW-1:0]   n3_stf;
    logic [MAGW+SIGW-1:0]  n3_rf, n3_rgf;
    logic [RESIDW-1:0]     n3_r;
    ttps_pkg::t_side       n3_side;

    always_comb begin
        n3_dsf = (2*SIGW)'(r2_sg) * (2*SIGW)'(ttps_pkg::SIG_ONE - r2_sg);
        n3_stf = (SQW+SIGW)'(r2_sq) * (SQW+SIGW)'(r2_s);
        n3_rf  = (MAGW+SIGW)'(r2_maga) * (MAGW+SIGW)'(r2_s);
        n3_rgf = (MAGW+SIGW)'(r2_magag) * (MAGW+SIGW)'(r2_sg);
        n3_r   = RESIDW'(RW'(n3_rf >> 16));
        n3_side = '0;
        case (r2_kind)
            ttps_pkg::KIND_MEASURABLE: begin
                n3_side.stress = PSW'(r2_sq);
                n3_side.resid  = -RESIDW'(r2_a);
            end
            ttps_pkg::KIND_LESS: begin
                n3_side.stress = PSW'(n3_stf >> 16);
                n3_side.resid  = r2_a[AW-1] ? n3_r : -n3_r;
            end
            default: begin
                n3_side = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_kind <= r2_kind;
            r3_ag   <= r2_ag;
            r3_sqg  <= r2_sqg;
            r3_dsg  <= DSW'(n3_dsf >> 16);
            r3_rg   <= RW'(n3_rgf >> 16);
            r3_mg   <= r2_mg;
            r3_side <= n3_side;
        end
    end

    // stage 4: x^2 * s(1-s)
    logic                  r4_valid;
    logic [1:0]            r4_kind;
    logic signed [AW-1:0]  r4_ag;
    logic [PRODW-1:0]      r4_prod;
    logic [RW-1:0]         r4_rg;
    logic [MW-1:0]         r4_mg;
    ttps_pkg::t_side       r4_side;

    logic [SQW+DSW-1:0]    n4_pf;

    assign n4_pf = (SQW+DSW)'(r3_sqg) * (SQW+DSW)'(r3_dsg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_kind <= r3_kind;
            r4_ag   <= r3_ag;
            r4_prod <= PRODW'(n4_pf >> 16);
            r4_rg   <= r3_rg;
            r4_mg   <= r3_mg;
            r4_side <= r3_side;
        end
    end

    // stage 5: gradient numerator, split into sign and magnitude
    logic                  r5_valid;
    logic [NUMW-1:0]       r5_mag;
    logic                  r5_neg;
    logic [MW-1:0]         r5_mg;
    ttps_pkg::t_side       r5_side;

    logic signed [NUMW-1:0] n5_num;
    logic [NUMW-1:0]        n5_ten, n5_r2;

    always_comb begin
        n5_ten = NUMW'(r4_prod) * NUMW'(ttps_pkg::SLOPE);
        n5_r2  = NUMW'(r4_rg) << 1;
        case (r4_kind)
            ttps_pkg::KIND_MEASURABLE: n5_num = NUMW'(r4_ag) <<< 1;
            ttps_pkg::KIND_LESS:       n5_num = r4_ag[AW-1] ? n5_ten - n5_r2 : n5_ten + n5_r2;
            default:                   n5_num = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_neg  <= n5_num[NUMW-1];
            r5_mag  <= n5_num[NUMW-1] ? NUMW'(-n5_num) : NUMW'(n5_num);
            r5_mg   <= r4_mg;
            r5_side <= r4_side;
        end
    end

    assign o_valid   = r5_valid;
    assign o_num_mag = r5_mag;
    assign o_neg     = r5_neg;
    assign o_mg      = r5_mg;
    assign o_side    = r5_side;

endmodule

// ===== design/ttps_div.sv =====
module ttps_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [ttps_pkg::NUMW-1:0]    i_num_mag,
    input  logic                         i_neg,
    input  logic [ttps_pkg::MW-1:0]      i_mg,
    input  ttps_pkg::t_side              i_side,
    output logic                         o_valid,
    output logic [ttps_pkg::DIVNP-1:0]   o_quot,
    output logic                         o_neg,
    output ttps_pkg::t_side              o_side
);

    localparam int MW    = ttps_pkg::MW;
    localparam int DSTG  = ttps_pkg::DSTG;
    localparam int DIVNP = ttps_pkg::DIVNP;

    // restoring divider, two quotient bits per stage
    logic               r_v    [DSTG];
    logic [MW-1:0]      r_rem  [DSTG];
    logic [DIVNP-1:0]   r_num  [DSTG];
    logic [DIVNP-1:0]   r_quo  [DSTG];
    logic               r_neg  [DSTG];
    logic [MW-1:0]      r_mg   [DSTG];
    ttps_pkg::t_side    r_side [DSTG];

    logic [MW-1:0]      p_rem [DSTG];
    logic [DIVNP-1:0]   p_num [DSTG];
    logic [DIVNP-1:0]   p_quo [DSTG];
    logic [MW-1:0]      p_mg  [DSTG];

    logic [MW-1:0]      n_rem [DSTG];
    logic [DIVNP-1:0]   n_num [DSTG];
    logic [DIVNP-1:0]   n_quo [DSTG];

    always_comb begin
        p_rem[0] = '0;
        p_num[0] = DIVNP'({i_num_mag, ttps_pkg::FRAC_BITS'(0)});
        p_quo[0] = '0;
        p_mg[0]  = i_mg;
        for (int k = 1; k < DSTG; k++) begin
            p_rem[k] = r_rem[k-1];
            p_num[k] = r_num[k-1];
            p_quo[k] = r_quo[k-1];
            p_mg[k]  = r_mg[k-1];
        end
    end

    always_comb begin : b_steps
        logic [MW:0] v_try;
        for (int k = 0; k < DSTG; k++) begin
            n_rem[k] = p_rem[k];
            n_num[k] = p_num[k];
            n_quo[k] = p_quo[k];
            for (int b = 0; b < 2; b++) begin
                v_try    = {n_rem[k], n_num[k][DIVNP-1]};
                n_num[k] = n_num[k] << 1;
                if (v_try >= {1'b0, p_mg[k]}) begin
                    n_rem[k] = MW'(v_try - {1'b0, p_mg[k]});
                    n_quo[k] = {n_quo[k][DIVNP-2:0], 1'b1};
                end else begin
                    n_rem[k] = v_try[MW-1:0];
                    n_quo[k] = {n_quo[k][DIVNP-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DSTG; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < DSTG; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0]  <= i_neg;
            r_side[0] <= i_side;
            for (int k = 1; k < DSTG; k++) begin
                r_neg[k]  <= r_neg[k-1];
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < DSTG; k++) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= n_num[k];
                r_quo[k] <= n_quo[k];
                r_mg[k]  <= p_mg[k];
            end
        end
    end

    assign o_valid = r_v[DSTG-1];
    assign o_quot  = r_quo[DSTG-1];
    assign o_neg   = r_neg[DSTG-1];
    assign o_side  = r_side[DSTG-1];

endmodule

// ===== design/ttps_out.sv =====
module ttps_out (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [ttps_pkg::DIVNP-1:0]   i_quot,
    input  logic                         i_neg,
    input  ttps_pkg::t_side              i_side,
    input  logic                         i_stall,
    output logic                         o_en,
    output logic                         o_valid,
    output ttps_pkg::t_out_item          o_item
);

    localparam int DIVNP   = ttps_pkg::DIVNP;
    localparam int PSW     = ttps_pkg::PSW;
    localparam int STRESSW = ttps_pkg::STRESSW;
    localparam int RESW    = ttps_pkg::RESW;
    localparam int GRADW   = ttps_pkg::GRADW;

    ttps_pkg::t_out_item n_item;
    logic                n_st_over, n_gr_over;

    always_comb begin
        n_st_over = |i_side.stress[PSW-1:STRESSW];
        if (i_neg) begin
            n_gr_over = (|i_quot[DIVNP-1:GRADW])
                        || (i_quot[GRADW-1] && (|i_quot[GRADW-2:0]));
        end else begin
            n_gr_over = |i_quot[DIVNP-1:GRADW-1];
        end
        n_item.stress   = n_st_over ? '1 : i_side.stress[STRESSW-1:0];
        n_item.residual = RESW'(i_side.resid);
        if (n_gr_over) begin
            n_item.gradient_base = i_neg ? {1'b1, (GRADW-1)'(0)} : {1'b0, {(GRADW-1){1'b1}}};
        end else begin
            n_item.gradient_base = i_neg ? -i_quot[GRADW-1:0] : i_quot[GRADW-1:0];
        end
        n_item.saturated = n_st_over | n_gr_over;
    end

    // output register plus one skid entry; pipeline holds while the skid is full
    logic                r_ovalid, r_skid_valid;
    ttps_pkg::t_out_item r_out, r_skid;
    logic                w_take, w_load;

    assign w_take = r_ovalid & ~i_stall;
    assign w_load = ~r_skid_valid & i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid     <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_load) begin
            if (r_ovalid && !w_take) begin
                r_skid_valid <= 1'b1;
            end
            r_ovalid <= 1'b1;
        end else if (w_take) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_load) begin
            if (r_ovalid && !w_take) begin
                r_skid <= n_item;
            end else begin
                r_out <= n_item;
            end
        end
    end

    assign o_en    = ~r_skid_valid;
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

endmodule

// ===== design/titer_point_stress_terms.sv =====
// Pipeline: 5 arithmetic stages, 29 divider stages at two quotient bits
// each, then 1 output register.
// Throughput: one item per cycle; the whole pipeline holds only while the
// output register and its skid entry are both full.
// Reset: synchronous, active low; clears all valid bits and sets the
// dilution step to 1.0.
module titer_point_stress_terms (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  ttps_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output ttps_pkg::t_out_item          o_out_item,
    input  logic                         i_cfg_wr_en,
    input  logic [ttps_pkg::STEPW-1:0]   i_cfg_wr_data
);

    logic [ttps_pkg::STEPW-1:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ttps_pkg::STEP_RESET;
        end else if (i_cfg_wr_en) begin
            r_step <= i_cfg_wr_data;
        end
    end

    logic                        w_en;
    logic                        w_f_valid;
    logic [ttps_pkg::NUMW-1:0]   w_f_mag;
    logic                        w_f_neg;
    logic [ttps_pkg::MW-1:0]     w_f_mg;
    ttps_pkg::t_side             w_f_side;

    logic                        w_d_valid;
    logic [ttps_pkg::DIVNP-1:0]  w_d_quot;
    logic                        w_d_neg;
    ttps_pkg::t_side             w_d_side;

    ttps_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_in_valid),
        .i_item    (i_in_item),
        .i_step    (r_step),
        .o_valid   (w_f_valid),
        .o_num_mag (w_f_mag),
        .o_neg     (w_f_neg),
        .o_mg      (w_f_mg),
        .o_side    (w_f_side)
    );

    ttps_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_f_valid),
        .i_num_mag (w_f_mag),
        .i_neg     (w_f_neg),
        .i_mg      (w_f_mg),
        .i_side    (w_f_side),
        .o_valid   (w_d_valid),
        .o_quot    (w_d_quot),
        .o_neg     (w_d_neg),
        .o_side    (w_d_side)
    );

    ttps_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .i_quot  (w_d_quot),
        .i_neg   (w_d_neg),
        .i_side  (w_d_side),
        .i_stall (i_out_stall),
        .o_en    (w_en),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

    assign o_in_stall = ~w_en;

endmodule

// ===== design/ttps_chk.sv =====
module ttps_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_stall,
    input logic                 i_out_valid,
    input logic                 i_out_stall,
    input ttps_pkg::t_out_item  i_out_item
);

    // held item stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> $stable(i_out_item))
        else $error("output item changed while stalled");

    // input side only stalls while a result is waiting
    a_stall_has_out: assert property (@(posedge i_clk)
        i_in_stall |-> i_out_valid)
        else $error("input stalled with no result pending");

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_stall)
        else $error("reset left pipeline busy");

    // a clipped value is never zero
    a_sat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.stress == '0 && i_out_item.residual == '0
        && i_out_item.gradient_base == '0 |-> !i_out_item.saturated)
        else $error("saturated flag on all-zero item");

endmodule

bind titer_point_stress_terms ttps_chk u_ttps_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);
